// File: sv/fct_pkg.sv
// Shared types, constants and hash mixing function of the flow counter table.
package fct_pkg;

  localparam int SLOTS_DEFAULT = 1024;
  localparam int COUNT_W = 17;
  localparam int THRESH_W = 16;
  localparam int MIX_STEPS = 9;
  localparam int HASH_STAGES = 2 * MIX_STEPS;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd1000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 17'd1;
  localparam logic [31:0] GOLDEN = 32'h9e3779b9;
  localparam logic [31:0] KEY_LEN = 32'd13;

  localparam logic REG_IDX_THRESHOLD = 1'b0;

  typedef struct packed {
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [31:0] dst;
    logic [31:0] src;
  } flow_key_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    flow_key_t          key;
  } slot_entry_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mix_t;

  typedef enum logic [1:0] {
    TBL_CLEAR,
    TBL_IDLE,
    TBL_CHECK
  } tbl_state_t;

  function automatic mix_t mix_line(input int step, input mix_t v);
    mix_t r;
    r = v;
    unique case (step)
      0: begin
        r.a = r.a - r.b - r.c;
        r.a = r.a ^ (r.c >> 13);
      end
      1: begin
        r.b = r.b - r.c - r.a;
        r.b = r.b ^ (r.a << 8);
      end
      2: begin
        r.c = r.c - r.a - r.b;
        r.c = r.c ^ (r.b >> 13);
      end
      3: begin
        r.a = r.a - r.b - r.c;
        r.a = r.a ^ (r.c >> 12);
      end
      4: begin
        r.b = r.b - r.c - r.a;
        r.b = r.b ^ (r.a << 16);
      end
      5: begin
        r.c = r.c - r.a - r.b;
        r.c = r.c ^ (r.b >> 5);
      end
      6: begin
        r.a = r.a - r.b - r.c;
        r.a = r.a ^ (r.c >> 3);
      end
      7: begin
        r.b = r.b - r.c - r.a;
        r.b = r.b ^ (r.a << 10);
      end
      8: begin
        r.c = r.c - r.a - r.b;
        r.c = r.c ^ (r.b >> 15);
      end
      default: begin
        r = v;
      end
    endcase
    return r;
  endfunction

endpackage

// File: sv/fct_hash.sv
// Pipelined key hash, one mixing line per stage.
module fct_hash (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fct_pkg::flow_key_t  in_key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_hash,
  output fct_pkg::flow_key_t  out_key
);

  localparam int LAST = fct_pkg::HASH_STAGES;

  logic [LAST:0]      st_valid;
  fct_pkg::mix_t      st_mix [LAST+1];
  fct_pkg::mix_t      st_mix_next [LAST+1];
  fct_pkg::flow_key_t st_key [LAST+1];
  logic               en;

  assign en = !st_valid[LAST] || out_ready;
  assign in_ready = en;

  assign st_mix_next[0] = '{a: fct_pkg::GOLDEN + in_key.src,
                            b: fct_pkg::GOLDEN + in_key.dst,
                            c: {in_key.dport, in_key.sport}};

  for (genvar s = 1; s <= LAST; s++) begin : g_stage
    fct_pkg::mix_t line_out;
    assign line_out = fct_pkg::mix_line((s - 1) % fct_pkg::MIX_STEPS, st_mix[s-1]);
    if (s == fct_pkg::MIX_STEPS) begin : g_tail
      assign st_mix_next[s] = '{a: line_out.a + {24'b0, st_key[s-1].proto},
                                b: line_out.b,
                                c: line_out.c + fct_pkg::KEY_LEN};
    end else begin : g_body
      assign st_mix_next[s] = line_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else if (en) begin
      st_valid <= {st_valid[LAST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_key[0] <= in_key;
      for (int i = 0; i <= LAST; i++) begin
        st_mix[i] <= st_mix_next[i];
      end
      for (int i = 1; i <= LAST; i++) begin
        st_key[i] <= st_key[i-1];
      end
    end
  end

  assign out_valid = st_valid[LAST];
  assign out_hash = st_mix[LAST].c;
  assign out_key = st_key[LAST];

endmodule

// File: sv/fct_slot_index.sv
// Reduction of the hash to a slot index by reciprocal multiplication.
module fct_slot_index #(
  parameter int SLOTS = fct_pkg::SLOTS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              in_hash,
  input  fct_pkg::flow_key_t       in_key,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [$clog2(SLOTS)-1:0] out_idx,
  output fct_pkg::flow_key_t       out_key
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SLOTS);
  localparam logic [31:0] DIVISOR = 32'(SLOTS);
  localparam logic [IDX_W:0] DIVISOR_REM = (IDX_W + 1)'(SLOTS);

  logic [2:0]         st_valid;
  logic               en;
  logic [31:0]        hash1;
  logic [63:0]        prod1;
  logic [IDX_W:0]     rem2;
  logic [IDX_W-1:0]   idx3;
  fct_pkg::flow_key_t key1;
  fct_pkg::flow_key_t key2;
  fct_pkg::flow_key_t key3;
  logic [63:0]        prod_next;
  logic [31:0]        qd;
  logic [31:0]        rem_full;

  assign en = !st_valid[2] || out_ready;
  assign in_ready = en;

  assign prod_next = in_hash * RECIP;
  assign qd = prod1[63:32] * DIVISOR;
  assign rem_full = hash1 - qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else if (en) begin
      st_valid <= {st_valid[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hash1 <= in_hash;
      prod1 <= prod_next;
      key1 <= in_key;
      rem2 <= rem_full[IDX_W:0];
      key2 <= key1;
      if (rem2 >= DIVISOR_REM) begin
        idx3 <= IDX_W'(rem2 - DIVISOR_REM);
      end else begin
        idx3 <= rem2[IDX_W-1:0];
      end
      key3 <= key2;
    end
  end

  assign out_valid = st_valid[2];
  assign out_idx = idx3;
  assign out_key = key3;

endmodule

// File: sv/fct_table.sv
// Flow table memory with read-modify-write sequencer and result register.
module fct_table #(
  parameter int SLOTS = fct_pkg::SLOTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [$clog2(SLOTS)-1:0]        in_idx,
  input  fct_pkg::flow_key_t              in_key,
  input  logic [fct_pkg::THRESH_W-1:0]    threshold,
  output logic                            clearing,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_report,
  output fct_pkg::slot_entry_t            out_entry
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  fct_pkg::slot_entry_t mem [SLOTS];

  fct_pkg::tbl_state_t  state;
  fct_pkg::tbl_state_t  state_next;
  logic [IDX_W-1:0]     clr_cnt;
  logic [IDX_W-1:0]     clr_cnt_next;
  logic [IDX_W-1:0]     idx;
  fct_pkg::flow_key_t   key;
  fct_pkg::slot_entry_t rd_data;
  logic                 rd_en;
  logic                 mem_we;
  logic [IDX_W-1:0]     wr_addr;
  fct_pkg::slot_entry_t wr_entry;
  logic                 load_out;
  logic                 rep_valid;
  fct_pkg::slot_entry_t rep_entry;
  logic [fct_pkg::COUNT_W-1:0] cnt_inc;
  logic                 slot_empty;
  logic                 slot_match;

  assign slot_empty = (rd_data.key == '0);
  assign slot_match = (rd_data.key == key);
  assign cnt_inc = (rd_data.count == fct_pkg::COUNT_MAX) ? rd_data.count
                                                         : rd_data.count + fct_pkg::COUNT_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fct_pkg::TBL_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    clr_cnt_next = clr_cnt;
    in_ready = 1'b0;
    rd_en = 1'b0;
    mem_we = 1'b0;
    wr_addr = idx;
    wr_entry = '0;
    load_out = 1'b0;
    rep_valid = 1'b0;
    rep_entry = '0;
    unique case (state)
      fct_pkg::TBL_CLEAR: begin
        mem_we = 1'b1;
        wr_addr = clr_cnt;
        clr_cnt_next = clr_cnt + IDX_W'(1);
        if (clr_cnt == IDX_LAST) begin
          state_next = fct_pkg::TBL_IDLE;
        end
      end
      fct_pkg::TBL_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rd_en = 1'b1;
          state_next = fct_pkg::TBL_CHECK;
        end
      end
      fct_pkg::TBL_CHECK: begin
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          mem_we = 1'b1;
          state_next = fct_pkg::TBL_IDLE;
          priority if (slot_empty) begin
            wr_entry = '{count: fct_pkg::COUNT_ONE, key: key};
          end else if (slot_match) begin
            if (cnt_inc > {1'b0, threshold}) begin
              rep_valid = 1'b1;
              rep_entry = '{count: cnt_inc, key: key};
              wr_entry = '0;
            end else begin
              wr_entry = '{count: cnt_inc, key: key};
            end
          end else begin
            rep_valid = 1'b1;
            rep_entry = rd_data;
            wr_entry = '{count: fct_pkg::COUNT_ONE, key: key};
          end
        end
      end
      default: begin
        state_next = fct_pkg::TBL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[in_idx];
      idx <= in_idx;
      key <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_report <= rep_valid;
      out_entry <= rep_entry;
    end
  end

  assign clearing = (state == fct_pkg::TBL_CLEAR);

endmodule

// File: sv/flow_counter_table_evict_report.sv
// Top level: hashed flow counter table with eviction reports and its register port.
// Path: hash pipeline, slot index pipeline, table read and check states, registered output.
// Throughput: the table takes no new packet until it has read and then written the slot
// of the last one; the hash and index stages take one packet a cycle unless held back.
// Reset: the threshold returns to 1000 and a clearing pass writes every slot to zero,
// one slot a cycle, during which no packet is accepted.
module flow_counter_table_evict_report #(
  parameter int SLOTS = fct_pkg::SLOTS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // source_address, destination_address, source_port, destination_port, protocol_number
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // report_source_address, report_destination_address, report_source_port,
  // report_destination_port, report_protocol, report_count, zero padding
  output logic [127:0] m_tdata,
  // report_valid
  output logic [0:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int IDX_W = $clog2(SLOTS);

  logic [fct_pkg::THRESH_W-1:0] threshold;
  logic                 clearing;
  logic                 hash_in_ready;
  logic                 hash_valid;
  logic                 hash_ready;
  logic [31:0]          hash_value;
  fct_pkg::flow_key_t   hash_key;
  logic                 idx_valid;
  logic                 idx_ready;
  logic [IDX_W-1:0]     idx_value;
  fct_pkg::flow_key_t   idx_key;
  logic                 out_report;
  fct_pkg::slot_entry_t out_entry;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= fct_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == fct_pkg::REG_IDX_THRESHOLD) begin
      threshold <= pwdata[fct_pkg::THRESH_W-1:0];
    end
  end

  assign prdata = (paddr[2] == fct_pkg::REG_IDX_THRESHOLD) ? {16'b0, threshold} : 32'b0;

  assign s_tready = hash_in_ready && !clearing;

  fct_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid && !clearing),
    .in_ready  (hash_in_ready),
    .in_key    (fct_pkg::flow_key_t'(s_tdata)),
    .out_valid (hash_valid),
    .out_ready (hash_ready),
    .out_hash  (hash_value),
    .out_key   (hash_key)
  );

  fct_slot_index #(
    .SLOTS (SLOTS)
  ) u_slot_index (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hash_valid),
    .in_ready  (hash_ready),
    .in_hash   (hash_value),
    .in_key    (hash_key),
    .out_valid (idx_valid),
    .out_ready (idx_ready),
    .out_idx   (idx_value),
    .out_key   (idx_key)
  );

  fct_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (idx_valid),
    .in_ready   (idx_ready),
    .in_idx     (idx_value),
    .in_key     (idx_key),
    .threshold  (threshold),
    .clearing   (clearing),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_report (out_report),
    .out_entry  (out_entry)
  );

  assign m_tdata = {7'b0, out_entry};
  assign m_tuser = out_report;

endmodule
